// ===== rtl/sbus_deframer_mode_select_assert.svh =====
// assertion macros used by the top-level rtl
`ifndef SBUS_DEFRAMER_MODE_SELECT_ASSERT_SVH
`define SBUS_DEFRAMER_MODE_SELECT_ASSERT_SVH

// same-cycle implication
`define SBD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sbd_pkg.sv =====
package sbd_pkg;

  localparam int CHANNEL_BITS   = 11;
  localparam int NUM_CHANNELS_C = 16;
  localparam int DATA_BYTES     = 22;
  localparam int FRAME_BITS     = DATA_BYTES * 8;
  localparam int FRAME_IDX_W    = $clog2(FRAME_BITS);
  localparam int IDX_W          = 4;
  localparam int PHASE_W        = 5;

  localparam logic [7:0] HEADER_BYTE  = 8'h0F;
  localparam int         LOST_POS     = 2;
  localparam int         FAILSAFE_POS = 3;

  localparam logic [1:0] MODE_ZERO = 2'd0;
  localparam logic [1:0] MODE_ONE  = 2'd1;
  localparam logic [1:0] MODE_TWO  = 2'd2;

  localparam logic [1:0] CFG_HIGH_THR = 2'd0;
  localparam logic [1:0] CFG_LOW_THR  = 2'd1;
  localparam logic [1:0] CFG_MODE_CH  = 2'd2;
  localparam logic [1:0] CFG_FALLBACK = 2'd3;

  localparam logic [CHANNEL_BITS-1:0] HIGH_THR_RST  = 11'd1500;
  localparam logic [CHANNEL_BITS-1:0] LOW_THR_RST   = 11'd800;
  localparam logic [IDX_W-1:0]        MODE_CH_RST   = 4'd4;
  localparam logic [CHANNEL_BITS-1:0] FALLBACK_RST  = 11'd1024;
  localparam logic [CHANNEL_BITS-1:0] SELECTOR_RST  = 11'd1024;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_DATA,
    PH_FLAG
  } col_phase_t;

  typedef enum logic {
    EM_IDLE,
    EM_SEND
  } emit_state_t;

  typedef struct packed {
    logic start;
    logic lost;
    logic failsafe;
  } frame_evt_t;

endpackage

// ===== rtl/sbd_collect.sv =====
module sbd_collect
  import sbd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  byte_acc,
  input  logic [7:0]            rx_byte,
  output logic [FRAME_BITS-1:0] frame_bits,
  output frame_evt_t            evt
);

  col_phase_t          state_r, state_nxt;
  logic [PHASE_W-1:0]  cnt_r, cnt_nxt;
  logic [FRAME_BITS-1:0] frame_r;
  logic                shift_en;
  logic                last_data;

  assign last_data = (cnt_r == PHASE_W'(DATA_BYTES - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      PH_HUNT: begin
        if (byte_acc && (rx_byte == HEADER_BYTE)) begin
          state_nxt = PH_DATA;
          cnt_nxt   = '0;
        end
      end
      PH_DATA: begin
        if (byte_acc) begin
          if (last_data) begin
            state_nxt = PH_FLAG;
          end else begin
            cnt_nxt = cnt_r + PHASE_W'(1);
          end
        end
      end
      PH_FLAG: begin
        if (byte_acc) begin
          state_nxt = PH_HUNT;
        end
      end
      default: state_nxt = PH_HUNT;
    endcase
  end

  // outputs
  always_comb begin
    shift_en     = 1'b0;
    evt.start    = 1'b0;
    evt.lost     = rx_byte[LOST_POS];
    evt.failsafe = rx_byte[FAILSAFE_POS];
    case (state_r)
      PH_DATA: shift_en  = byte_acc;
      PH_FLAG: evt.start = byte_acc;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PH_HUNT;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // byte 0 ends up in the low bits after the last data word
  always_ff @(posedge clk) begin
    if (shift_en) begin
      frame_r <= {rx_byte, frame_r[FRAME_BITS-1:8]};
    end
  end

  assign frame_bits = frame_r;

endmodule

// ===== rtl/sbd_emit.sv =====
module sbd_emit
  import sbd_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_C
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  frame_evt_t              evt,
  input  logic [FRAME_BITS-1:0]   frame_bits,
  input  logic [CHANNEL_BITS-1:0] fallback_value,
  input  logic [1:0]              drive_mode,
  input  logic                    out_stall,
  output logic                    busy,
  output logic                    out_valid,
  output logic [IDX_W-1:0]        out_channel_index,
  output logic [CHANNEL_BITS-1:0] out_channel_value,
  output logic                    out_last_channel,
  output logic                    out_lost_flag,
  output logic                    out_failsafe_flag,
  output logic [1:0]              out_drive_mode_out
);

  emit_state_t             state_r, state_nxt;
  logic [IDX_W-1:0]        cnt_r;
  logic [FRAME_BITS-1:0]   sr_r;
  logic                    lost_r, fs_r;
  logic                    send_go;
  logic                    last_now;
  logic                    out_valid_r;
  logic [IDX_W-1:0]        index_r;
  logic [CHANNEL_BITS-1:0] value_r;
  logic                    last_r, olost_r, ofs_r;
  logic [1:0]              mode_r;

  assign last_now = (cnt_r == IDX_W'(NUM_CHANNELS - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      EM_IDLE: if (evt.start) state_nxt = EM_SEND;
      EM_SEND: if (send_go && last_now) state_nxt = EM_IDLE;
      default: state_nxt = EM_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy    = 1'b0;
    send_go = 1'b0;
    case (state_r)
      EM_SEND: begin
        busy    = 1'b1;
        send_go = !out_valid_r || !out_stall;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= EM_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (send_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (evt.start) begin
        cnt_r <= '0;
      end else if (send_go) begin
        cnt_r <= cnt_r + IDX_W'(1);
      end
    end
  end

  // one channel digit leaves the shifter per word
  always_ff @(posedge clk) begin
    if (evt.start) begin
      sr_r   <= frame_bits;
      lost_r <= evt.lost;
      fs_r   <= evt.failsafe;
    end else if (send_go) begin
      sr_r <= sr_r >> CHANNEL_BITS;
    end
    if (send_go) begin
      index_r <= cnt_r;
      value_r <= (lost_r || fs_r) ? fallback_value : sr_r[CHANNEL_BITS-1:0];
      last_r  <= last_now;
      olost_r <= lost_r;
      ofs_r   <= fs_r;
      mode_r  <= drive_mode;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_channel_index  = index_r;
  assign out_channel_value  = value_r;
  assign out_last_channel   = last_r;
  assign out_lost_flag      = olost_r;
  assign out_failsafe_flag  = ofs_r;
  assign out_drive_mode_out = mode_r;

endmodule

// ===== rtl/sbus_deframer_mode_select.sv =====
// first channel word: after the flag byte is taken the emitter enters its send state, then registers the word
// throughput: header and data bytes are taken one per cycle; after the flag byte
//   the input stalls while the channel shifter emits one 11-bit channel per cycle
//   (held while out_stall blocks the output) until all NUM_CHANNELS channels are sent
// reset: synchronous active-low rst_n returns to header hunt, mode 1, selector 1024,
//   registers to defaults; the frame shift register is not cleared
module sbus_deframer_mode_select
  import sbd_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_C
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [1:0]              cfg_index,
  input  logic [CHANNEL_BITS-1:0] cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_rx_byte,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [IDX_W-1:0]        out_channel_index,
  output logic [CHANNEL_BITS-1:0] out_channel_value,
  output logic                    out_last_channel,
  output logic                    out_lost_flag,
  output logic                    out_failsafe_flag,
  output logic [1:0]              out_drive_mode_out
);

  `include "sbus_deframer_mode_select_assert.svh"

  logic [CHANNEL_BITS-1:0] high_thr_r, low_thr_r, fallback_r;
  logic [IDX_W-1:0]        mode_ch_r;
  logic [CHANNEL_BITS-1:0] selector_last_r;
  logic [1:0]              drive_mode_r, drive_mode_nxt;
  logic [FRAME_BITS-1:0]   frame_bits;
  frame_evt_t              evt;
  logic                    busy;
  logic                    in_acc;
  logic [FRAME_IDX_W-1:0]  sel_base;
  logic [CHANNEL_BITS-1:0] sel;

  assign in_stall = busy;
  assign in_acc   = in_valid && !in_stall;

  sbd_collect u_collect (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_acc   (in_acc),
    .rx_byte    (in_rx_byte),
    .frame_bits (frame_bits),
    .evt        (evt)
  );

  sbd_emit #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_emit (
    .clk                (clk),
    .rst_n              (rst_n),
    .evt                (evt),
    .frame_bits         (frame_bits),
    .fallback_value     (fallback_r),
    .drive_mode         (drive_mode_r),
    .out_stall          (out_stall),
    .busy               (busy),
    .out_valid          (out_valid),
    .out_channel_index  (out_channel_index),
    .out_channel_value  (out_channel_value),
    .out_last_channel   (out_last_channel),
    .out_lost_flag      (out_lost_flag),
    .out_failsafe_flag  (out_failsafe_flag),
    .out_drive_mode_out (out_drive_mode_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_thr_r <= HIGH_THR_RST;
      low_thr_r  <= LOW_THR_RST;
      mode_ch_r  <= MODE_CH_RST;
      fallback_r <= FALLBACK_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_HIGH_THR: high_thr_r <= cfg_wdata;
        CFG_LOW_THR:  low_thr_r  <= cfg_wdata;
        CFG_MODE_CH:  mode_ch_r  <= cfg_wdata[IDX_W-1:0];
        CFG_FALLBACK: fallback_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // selector channel straight from the frame buffer
  assign sel_base = FRAME_IDX_W'(mode_ch_r) * FRAME_IDX_W'(CHANNEL_BITS);
  assign sel      = frame_bits[sel_base +: CHANNEL_BITS];

  always_comb begin
    drive_mode_nxt = drive_mode_r;
    if (evt.lost || evt.failsafe) begin
      drive_mode_nxt = MODE_TWO;
    end else if (sel != selector_last_r) begin
      if (sel > high_thr_r) begin
        drive_mode_nxt = MODE_TWO;
      end else if (sel > low_thr_r) begin
        drive_mode_nxt = MODE_ONE;
      end else if (sel < low_thr_r) begin
        drive_mode_nxt = MODE_ZERO;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_mode_r    <= MODE_ONE;
      selector_last_r <= SELECTOR_RST;
    end else if (evt.start) begin
      drive_mode_r    <= drive_mode_nxt;
      selector_last_r <= sel;
    end
  end

  `SBD_ASSERT_NOW(a_start_idle, evt.start, !busy, "frame start while emitting")
  `SBD_ASSERT_NOW(a_mode_legal, 1'b1, drive_mode_r != 2'd3, "illegal drive mode")
  `SBD_ASSERT_NOW(a_last_index, out_valid && out_last_channel,
    out_channel_index == IDX_W'(NUM_CHANNELS - 1), "last marker on wrong channel")
  `SBD_ASSERT_NEXT(a_flag_mode, evt.start && (evt.lost || evt.failsafe),
    drive_mode_r == MODE_TWO, "flagged frame did not force mode two")

endmodule
